// ----- sv/frf_pkg.sv -----
// shared constants, types and helpers of the frequency response ratio block
package frf_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;

    localparam int DIVW = 2 * FRAC_BITS + 66;
    localparam int DCW  = $clog2(DIVW + 1);
    localparam int SQP  = (DIVW + 1) / 2;
    localparam int QW   = 2 * SQP;
    localparam int SQCW = $clog2(SQP + 1);
    localparam int CSW  = $clog2(CORDIC_STEPS + 1);

    localparam logic [63:0] PDEG     = 64'd1000000000000;
    localparam logic [63:0] PDEG_90  = 64'd90000000000000;
    localparam logic [63:0] PDEG_180 = 64'd180000000000000;

    typedef enum logic [2:0] {
        FMT_CPLX  = 3'd0,
        FMT_REAL  = 3'd1,
        FMT_IMAG  = 3'd2,
        FMT_MAG   = 3'd3,
        FMT_PHASE = 3'd4
    } fmt_t;

    typedef struct packed {
        logic [31:0] nr;
        logic [31:0] ni;
        logic [31:0] dr;
        logic [31:0] di;
        logic        nrn;
        logic        nin;
        logic        drn;
        logic        din;
        logic        zf;
        fmt_t        fmt;
    } bin_t;

    function automatic logic [63:0] atan_pdeg(input logic [4:0] i);
        logic [63:0] r;
        case (i)
            5'd0:  r = 64'd45000000000000;
            5'd1:  r = 64'd26565051177078;
            5'd2:  r = 64'd14036243467926;
            5'd3:  r = 64'd7125016348902;
            5'd4:  r = 64'd3576334374997;
            5'd5:  r = 64'd1789910608246;
            5'd6:  r = 64'd895173710211;
            5'd7:  r = 64'd447614170861;
            5'd8:  r = 64'd223810500369;
            5'd9:  r = 64'd111905677066;
            5'd10: r = 64'd55952891894;
            5'd11: r = 64'd27976452617;
            5'd12: r = 64'd13988227142;
            5'd13: r = 64'd6994113675;
            5'd14: r = 64'd3497056851;
            5'd15: r = 64'd1748528427;
            5'd16: r = 64'd874264214;
            5'd17: r = 64'd437132107;
            5'd18: r = 64'd218566053;
            5'd19: r = 64'd109283027;
            5'd20: r = 64'd54641513;
            5'd21: r = 64'd27320757;
            5'd22: r = 64'd13660378;
            5'd23: r = 64'd6830189;
            5'd24: r = 64'd3415095;
            5'd25: r = 64'd1707547;
            5'd26: r = 64'd853774;
            5'd27: r = 64'd426887;
            5'd28: r = 64'd213443;
            5'd29: r = 64'd106722;
            5'd30: r = 64'd53361;
            default: r = 64'd0;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] sat32(input logic neg, input logic [DIVW:0] q);
        logic        big;
        logic [31:0] r;
        big = |q[DIVW:31];
        if (neg) begin
            r = big ? 32'h8000_0000 : (32'd0 - q[31:0]);
        end else begin
            r = big ? 32'h7fff_ffff : q[31:0];
        end
        return r;
    endfunction

endpackage

// ----- sv/frf_front.sv -----
// front end: format register, input acceptance and bin classification
module frf_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_output_format,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_numerator_re,
    input  logic signed [31:0] s_numerator_im,
    input  logic signed [31:0] s_denominator_re,
    input  logic signed [31:0] s_denominator_im,
    input  logic               q_full,
    output logic               push,
    output frf_pkg::bin_t      push_data
);
    import frf_pkg::*;

    fmt_t fmt_reg;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign push      = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg <= FMT_CPLX;
        end else if (cfg_valid) begin
            case (cfg_output_format)
                3'd1:    fmt_reg <= FMT_REAL;
                3'd2:    fmt_reg <= FMT_IMAG;
                3'd3:    fmt_reg <= FMT_MAG;
                3'd4:    fmt_reg <= FMT_PHASE;
                default: fmt_reg <= FMT_CPLX;
            endcase
        end
    end

    always_comb begin
        push_data.nr  = mag32(s_numerator_re);
        push_data.ni  = mag32(s_numerator_im);
        push_data.dr  = mag32(s_denominator_re);
        push_data.di  = mag32(s_denominator_im);
        push_data.nrn = s_numerator_re[31];
        push_data.nin = s_numerator_im[31];
        push_data.drn = s_denominator_re[31];
        push_data.din = s_denominator_im[31];
        push_data.zf  = (s_denominator_re == 32'sd0) && (s_denominator_im == 32'sd0);
        push_data.fmt = fmt_reg;
    end

endmodule

// ----- sv/frf_queue.sv -----
// two-entry queue between front end and back end
module frf_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  frf_pkg::bin_t push_data,
    output logic          full,
    output logic          pop_valid,
    input  logic          pop,
    output frf_pkg::bin_t pop_data
);
    import frf_pkg::*;

    bin_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign full      = cnt_reg == 2'd2;
    assign pop_valid = cnt_reg != 2'd0;
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

// ----- sv/frf_back.sv -----
// back end: products, shared divider, square root, cordic and result register
module frf_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  frf_pkg::bin_t      q_data,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_result_value,
    output logic               m_last_of_bin,
    output logic               m_zero_divisor
);
    import frf_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL, ST_SUM, ST_DIV, ST_DIVEND, ST_SQRT, ST_SQEND,
        ST_NORM, ST_CORD, ST_BASE, ST_EMIT
    } state_t;

    state_t      state_reg;
    bin_t        bin_reg;
    logic        second_reg;
    logic [2:0]  mstep_reg;
    logic [63:0] prod_reg [8];
    logic [63:0] re_m_reg, im_m_reg;
    logic        ren_reg, imn_reg;
    logic [63:0] den_reg;
    logic [DIVW-1:0] div_num_reg;
    logic [63:0]     div_rem_reg;
    logic [63:0]     div_d_reg;
    logic [DCW-1:0]  div_cnt_reg;
    logic            div_neg_reg;
    logic [QW-1:0]   sq_in_reg;
    logic [SQP+1:0]  sq_rem_reg;
    logic [SQP-1:0]  sq_root_reg;
    logic [SQCW-1:0] sq_cnt_reg;
    logic [63:0]     cx_reg, cy_reg, cz_reg;
    logic [CSW-1:0]  cstep_reg;
    logic [31:0]     res_reg;
    logic            res_last_reg;
    logic            m_valid_reg;
    logic [31:0]     m_value_reg;
    logic            m_last_reg;
    logic            m_zf_reg;

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [64:0] re_s, im_s;
    logic [63:0] den_s, nn_s;
    logic [64:0] div_r2;
    logic        div_ge;
    logic [64:0] div_sub;
    logic        div_inc;
    logic [SQP+3:0] sq_rem2;
    logic [SQP+3:0] sq_trial;
    logic           sq_ge;
    logic [SQP:0]   sq_rnd;
    logic signed [63:0] cx_s, cy_s, cdx, cdy;
    logic [63:0] cmx;
    logic [63:0] zc, base;

    function automatic logic [64:0] sadd(input logic an, input logic [63:0] am,
                                         input logic bn, input logic [63:0] bm);
        logic [63:0] m;
        logic        rn;
        if (an == bn) begin
            m  = am + bm;
            rn = an;
        end else if (am >= bm) begin
            m  = am - bm;
            rn = an;
        end else begin
            m  = bm - am;
            rn = bn;
        end
        if (m == 64'd0) begin
            rn = 1'b0;
        end
        return {rn, m};
    endfunction

    assign q_pop          = (state_reg == ST_IDLE) && q_valid;
    assign m_valid        = m_valid_reg;
    assign m_result_value = m_value_reg;
    assign m_last_of_bin  = m_last_reg;
    assign m_zero_divisor = m_zf_reg;

    always_comb begin
        case (mstep_reg)
            3'd0:    begin mul_a = bin_reg.nr; mul_b = bin_reg.dr; end
            3'd1:    begin mul_a = bin_reg.ni; mul_b = bin_reg.di; end
            3'd2:    begin mul_a = bin_reg.ni; mul_b = bin_reg.dr; end
            3'd3:    begin mul_a = bin_reg.nr; mul_b = bin_reg.di; end
            3'd4:    begin mul_a = bin_reg.dr; mul_b = bin_reg.dr; end
            3'd5:    begin mul_a = bin_reg.di; mul_b = bin_reg.di; end
            3'd6:    begin mul_a = bin_reg.nr; mul_b = bin_reg.nr; end
            default: begin mul_a = bin_reg.ni; mul_b = bin_reg.ni; end
        endcase
        prod = 64'(mul_a) * 64'(mul_b);

        re_s  = sadd(bin_reg.nrn ^ bin_reg.drn, prod_reg[0],
                     bin_reg.nin ^ bin_reg.din, prod_reg[1]);
        im_s  = sadd(bin_reg.nin ^ bin_reg.drn, prod_reg[2],
                     !(bin_reg.nrn ^ bin_reg.din), prod_reg[3]);
        den_s = prod_reg[4] + prod_reg[5];
        nn_s  = prod_reg[6] + prod_reg[7];

        div_r2  = {div_rem_reg, div_num_reg[DIVW-1]};
        div_ge  = div_r2 >= {1'b0, div_d_reg};
        div_sub = div_r2 - {1'b0, div_d_reg};
        div_inc = {div_rem_reg, 1'b0} >= {1'b0, div_d_reg};

        sq_rem2  = {sq_rem_reg, sq_in_reg[QW-1:QW-2]};
        sq_trial = (SQP+4)'({sq_root_reg, 2'b01});
        sq_ge    = sq_rem2 >= sq_trial;
        sq_rnd   = ({1'b0, sq_root_reg} + (SQP+1)'(1)) >> 1;

        cx_s = $signed(cx_reg);
        cy_s = $signed(cy_reg);
        cdx  = cy_s >>> cstep_reg;
        cdy  = cx_s >>> cstep_reg;
        cmx  = (cx_reg > cy_reg) ? cx_reg : cy_reg;

        if (cz_reg[63]) begin
            zc = 64'd0;
        end else if (cz_reg > PDEG_90) begin
            zc = PDEG_90;
        end else begin
            zc = cz_reg;
        end
        base = ren_reg ? (PDEG_180 - zc) : zc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            second_reg  <= 1'b0;
        end else begin
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        bin_reg    <= q_data;
                        second_reg <= 1'b0;
                        mstep_reg  <= 3'd0;
                        if (q_data.zf) begin
                            res_reg      <= 32'd0;
                            res_last_reg <= q_data.fmt != FMT_CPLX;
                            state_reg    <= ST_EMIT;
                        end else begin
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    prod_reg[mstep_reg] <= prod;
                    mstep_reg           <= mstep_reg + 3'd1;
                    if (mstep_reg == 3'd7) begin
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    re_m_reg    <= re_s[63:0];
                    ren_reg     <= re_s[64];
                    im_m_reg    <= im_s[63:0];
                    imn_reg     <= im_s[64];
                    den_reg     <= den_s;
                    div_rem_reg <= 64'd0;
                    div_d_reg   <= den_s;
                    div_cnt_reg <= DCW'(DIVW);
                    case (bin_reg.fmt)
                        FMT_IMAG: begin
                            div_num_reg <= DIVW'(im_s[63:0]) << FRAC_BITS;
                            div_neg_reg <= im_s[64];
                            state_reg   <= ST_DIV;
                        end
                        FMT_MAG: begin
                            div_num_reg <= DIVW'(nn_s) << (2 * FRAC_BITS + 2);
                            div_neg_reg <= 1'b0;
                            state_reg   <= ST_DIV;
                        end
                        FMT_PHASE: begin
                            cx_reg <= re_s[63:0];
                            cy_reg <= im_s[63:0];
                            cz_reg <= 64'd0;
                            cstep_reg <= '0;
                            if (re_s[63:0] == 64'd0 && im_s[63:0] == 64'd0) begin
                                res_reg      <= 32'd0;
                                res_last_reg <= 1'b1;
                                state_reg    <= ST_EMIT;
                            end else begin
                                state_reg <= ST_NORM;
                            end
                        end
                        default: begin
                            div_num_reg <= DIVW'(re_s[63:0]) << FRAC_BITS;
                            div_neg_reg <= re_s[64];
                            state_reg   <= ST_DIV;
                        end
                    endcase
                end
                ST_DIV: begin
                    div_rem_reg <= div_ge ? div_sub[63:0] : div_r2[63:0];
                    div_num_reg <= {div_num_reg[DIVW-2:0], div_ge};
                    div_cnt_reg <= div_cnt_reg - DCW'(1);
                    if (div_cnt_reg == DCW'(1)) begin
                        state_reg <= ST_DIVEND;
                    end
                end
                ST_DIVEND: begin
                    if (bin_reg.fmt == FMT_MAG) begin
                        sq_in_reg   <= QW'(div_num_reg);
                        sq_rem_reg  <= '0;
                        sq_root_reg <= '0;
                        sq_cnt_reg  <= '0;
                        state_reg   <= ST_SQRT;
                    end else begin
                        res_reg <= sat32(div_neg_reg,
                                         {1'b0, div_num_reg} + (DIVW+1)'(div_inc));
                        res_last_reg <= (bin_reg.fmt != FMT_CPLX) || second_reg;
                        state_reg    <= ST_EMIT;
                    end
                end
                ST_SQRT: begin
                    sq_rem_reg  <= sq_ge ? (SQP+2)'(sq_rem2 - sq_trial)
                                         : sq_rem2[SQP+1:0];
                    sq_root_reg <= {sq_root_reg[SQP-2:0], sq_ge};
                    sq_in_reg   <= sq_in_reg << 2;
                    sq_cnt_reg  <= sq_cnt_reg + SQCW'(1);
                    if (sq_cnt_reg == SQCW'(SQP - 1)) begin
                        state_reg <= ST_SQEND;
                    end
                end
                ST_SQEND: begin
                    res_reg      <= sat32(1'b0, (DIVW+1)'(sq_rnd));
                    res_last_reg <= 1'b1;
                    state_reg    <= ST_EMIT;
                end
                ST_NORM: begin
                    if (cmx[63:60] != 4'd0) begin
                        cx_reg <= cx_reg >> 1;
                        cy_reg <= cy_reg >> 1;
                    end else if (!cmx[59]) begin
                        cx_reg <= cx_reg << 1;
                        cy_reg <= cy_reg << 1;
                    end else begin
                        state_reg <= ST_CORD;
                    end
                end
                ST_CORD: begin
                    if (!cy_s[63]) begin
                        cx_reg <= 64'(cx_s + cdx);
                        cy_reg <= 64'(cy_s - cdy);
                        cz_reg <= cz_reg + atan_pdeg(5'(cstep_reg));
                    end else begin
                        cx_reg <= 64'(cx_s - cdx);
                        cy_reg <= 64'(cy_s + cdy);
                        cz_reg <= cz_reg - atan_pdeg(5'(cstep_reg));
                    end
                    cstep_reg <= cstep_reg + CSW'(1);
                    if (cstep_reg == CSW'(CORDIC_STEPS - 1)) begin
                        state_reg <= ST_BASE;
                    end
                end
                ST_BASE: begin
                    div_num_reg <= DIVW'(base) << FRAC_BITS;
                    div_rem_reg <= 64'd0;
                    div_d_reg   <= PDEG;
                    div_neg_reg <= imn_reg;
                    div_cnt_reg <= DCW'(DIVW);
                    state_reg   <= ST_DIV;
                end
                ST_EMIT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_value_reg <= res_reg;
                        m_last_reg  <= res_last_reg;
                        m_zf_reg    <= bin_reg.zf;
                        if (bin_reg.fmt == FMT_CPLX && !second_reg) begin
                            second_reg <= 1'b1;
                            if (bin_reg.zf) begin
                                res_reg      <= 32'd0;
                                res_last_reg <= 1'b1;
                            end else begin
                                div_num_reg <= DIVW'(im_m_reg) << FRAC_BITS;
                                div_rem_reg <= 64'd0;
                                div_d_reg   <= den_reg;
                                div_neg_reg <= imn_reg;
                                div_cnt_reg <= DCW'(DIVW);
                                state_reg   <= ST_DIV;
                            end
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- sv/frf_complex_ratio_format.sv -----
// top level of the frequency response ratio block with output formatting
// a real or imaginary value takes one pass of the bit-serial divider, a complex result takes
// two divider passes, and magnitude adds a square root pass after its divider pass
// throughput: one bin per back end pass; the bit-serial divider sets the figure
// a two-entry queue lets up to two bins be taken while the back end works
// reset: synchronous active-low aresetn clears the queue, sequencer and output valid
// and sets the format to complex
module frf_complex_ratio_format (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_output_format,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_numerator_re,
    input  logic signed [31:0] s_numerator_im,
    input  logic signed [31:0] s_denominator_re,
    input  logic signed [31:0] s_denominator_im,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_result_value,
    output logic               m_last_of_bin,
    output logic               m_zero_divisor
);
    import frf_pkg::*;

    logic q_full;
    logic push;
    bin_t push_data;
    logic pop_valid;
    logic pop;
    bin_t pop_data;

    frf_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_output_format (cfg_output_format),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_numerator_re    (s_numerator_re),
        .s_numerator_im    (s_numerator_im),
        .s_denominator_re  (s_denominator_re),
        .s_denominator_im  (s_denominator_im),
        .q_full            (q_full),
        .push              (push),
        .push_data         (push_data)
    );

    frf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_data  (pop_data)
    );

    frf_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (pop_valid),
        .q_data         (pop_data),
        .q_pop          (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value),
        .m_last_of_bin  (m_last_of_bin),
        .m_zero_divisor (m_zero_divisor)
    );

endmodule

// ----- sv/frf_checker.sv -----
// port-level checks of the frequency response ratio block and their binding
module frf_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               cfg_valid,
    input logic               cfg_ready,
    input logic [2:0]         cfg_output_format,
    input logic               s_valid,
    input logic               s_ready,
    input logic signed [31:0] s_numerator_re,
    input logic signed [31:0] s_numerator_im,
    input logic signed [31:0] s_denominator_re,
    input logic signed [31:0] s_denominator_im,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_result_value,
    input logic               m_last_of_bin,
    input logic               m_zero_divisor
);

    // a stalled result transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_value)
                                && $stable(m_last_of_bin) && $stable(m_zero_divisor))
        else $error("result changed while stalled");

    // zero divisor forces a zero value
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_zero_divisor |-> m_result_value == 32'sd0)
        else $error("zero divisor with nonzero value");

    // reset empties the result register
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // format register is always writable
    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind frf_complex_ratio_format frf_checker u_chk (.*);
